// File: rtl/core/priority_load_shed_selector_core_macros.svh
// ----------------------------------------------------------------------------
// priority_load_shed_selector_core_macros
// assertion helpers for the load shed selector core rtl
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LOAD_SHED_SELECTOR_CORE_MACROS_SVH
`define PRIORITY_LOAD_SHED_SELECTOR_CORE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define PLSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define PLSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/plss_pkg.sv
// ----------------------------------------------------------------------------
// plss_pkg
// types and constants of the priority load shed selector
// ----------------------------------------------------------------------------
package plss_pkg;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // register codes, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_SHED_TH    = 2'd0,
        REG_RESTORE_TH = 2'd1,
        REG_MIN_DWELL  = 2'd2,
        REG_CRIT_PRIO  = 2'd3
    } t_reg;

    localparam logic [15:0] SHED_TH_RST    = 16'd19661;
    localparam logic [15:0] RESTORE_TH_RST = 16'd45875;
    localparam logic [31:0] MIN_DWELL_RST  = 32'd3600;
    localparam logic [3:0]  CRIT_PRIO_RST  = 4'd0;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_EMERGENCY = 2'd1,
        MODE_LOW       = 2'd2,
        MODE_RECOVERY  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [15:0] shed_th;
        logic [15:0] restore_th;
        logic [31:0] min_dwell;
        logic [3:0]  crit_prio;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        time_now;
        logic [15:0]        soc_level;
        logic signed [23:0] headroom;
        logic               load_is_shed;
        logic [3:0]         load_priority;
        logic [22:0]        load_demand;
        logic               last_load;
    } t_load;

    typedef struct packed {
        logic       act_valid;
        logic [3:0] target_index;
        logic       shed_not_restore;
    } t_act;

endpackage

// File: rtl/core/plss_chan_if.sv
// ----------------------------------------------------------------------------
// plss_chan_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface plss_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/plss_cfg_regs.sv
// ----------------------------------------------------------------------------
// plss_cfg_regs
// apb register file for thresholds, dwell time and critical priority
// ----------------------------------------------------------------------------
module plss_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plss_pkg::CFG_AW-1:0]  paddr,
    input  logic [plss_pkg::CFG_DW-1:0]  pwdata,
    output logic [plss_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output plss_pkg::t_cfg               o_cfg
);
    import plss_pkg::*;

    t_cfg r_cfg;
    t_reg w_sel;
    logic w_wr;

    assign w_sel = t_reg'(paddr[3:2]);
    assign w_wr  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shed_th    <= SHED_TH_RST;
            r_cfg.restore_th <= RESTORE_TH_RST;
            r_cfg.min_dwell  <= MIN_DWELL_RST;
            r_cfg.crit_prio  <= CRIT_PRIO_RST;
        end else if (w_wr) begin
            case (w_sel)
                REG_SHED_TH:    r_cfg.shed_th    <= pwdata[15:0];
                REG_RESTORE_TH: r_cfg.restore_th <= pwdata[15:0];
                REG_MIN_DWELL:  r_cfg.min_dwell  <= pwdata[31:0];
                REG_CRIT_PRIO:  r_cfg.crit_prio  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_SHED_TH:    prdata = {16'd0, r_cfg.shed_th};
            REG_RESTORE_TH: prdata = {16'd0, r_cfg.restore_th};
            REG_MIN_DWELL:  prdata = r_cfg.min_dwell;
            REG_CRIT_PRIO:  prdata = {28'd0, r_cfg.crit_prio};
            default:        prdata = '0;
        endcase
    end
endmodule

// File: rtl/core/priority_load_shed_selector_core.sv
// ----------------------------------------------------------------------------
// priority_load_shed_selector_core
// picks at most one load to shed or restore per update of load records
// ----------------------------------------------------------------------------
// channel  | dir | payload                                     | beat
// i_load   | in  | time, soc, headroom, shed, prio, demand, last | one load record
// o_act    | out | act_valid, target_index, shed_not_restore     | one per update
// apb      | in  | shed/restore thresholds, min dwell, crit prio | register write
//
// one record per cycle unless an action stalls; a record is compared in the cycle
// after acceptance; an update's action is registered from its last record
// the change time table read is registered at acceptance, with write bypass
// reset: synchronous active low, clears all change marks at once
// a stalled action holds the last record of the next update in the input stage
module priority_load_shed_selector_core #(
    parameter int LOAD_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    plss_chan_if.sink                    i_load,
    plss_chan_if.source                  o_act,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plss_pkg::CFG_AW-1:0]  paddr,
    input  logic [plss_pkg::CFG_DW-1:0]  pwdata,
    output logic [plss_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import plss_pkg::*;

    `include "priority_load_shed_selector_core_macros.svh"

    localparam int POS_W = $clog2(LOAD_SLOTS + 1);
    localparam int IDX_W = (LOAD_SLOTS > 1) ? $clog2(LOAD_SLOTS) : 1;
    localparam logic [POS_W-1:0] POS_END = POS_W'(LOAD_SLOTS);

    t_cfg w_cfg;

    plss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // accept side: record position and table read
    logic [POS_W-1:0] r_acc_pos;
    logic [POS_W-1:0] n_acc_pos;
    logic             w_acc;
    logic [IDX_W-1:0] w_rd_addr;

    // compare stage
    logic               r_s1_valid;
    t_load              r_s1;
    logic [POS_W-1:0]   r_s1_pos;
    logic [31:0]        r_rd;
    logic [31:0]        r_ctime [LOAD_SLOTS];
    logic [LOAD_SLOTS-1:0] r_seen;

    // running update state
    logic               r_best_found;
    logic [IDX_W-1:0]   r_best_idx;
    logic [3:0]         r_best_prio;
    t_mode              r_mode;
    logic [31:0]        r_time;
    logic signed [23:0] r_head;

    // output stage
    logic r_out_valid;
    t_act r_out;

    logic               w_first;
    logic               w_slot_ok;
    logic [IDX_W-1:0]   w_sidx;
    t_mode              w_mode;
    logic [31:0]        w_time;
    logic signed [23:0] w_head;
    logic [31:0]        w_elapsed;
    logic               w_dwell_ok;
    logic               w_found;
    logic               w_cand;
    logic               w_better;
    logic               w_take;
    logic               n_best_found;
    logic [IDX_W-1:0]   n_best_idx;
    logic [3:0]         n_best_prio;
    logic               w_out_free;
    logic               w_s1_fire;
    logic               w_stamp;
    logic [IDX_W+3:0]   w_idx_ext;
    t_act               n_out;

    assign w_out_free = !r_out_valid || o_act.ready;
    assign w_s1_fire  = r_s1_valid && (!r_s1.last_load || w_out_free);
    assign i_load.ready = !r_s1_valid || w_s1_fire;
    assign w_acc = i_load.valid && i_load.ready;

    always_comb begin
        if (i_load.data.last_load) begin
            n_acc_pos = '0;
        end else if (r_acc_pos < POS_END) begin
            n_acc_pos = r_acc_pos + 1'b1;
        end else begin
            n_acc_pos = r_acc_pos;
        end
        w_rd_addr = (r_acc_pos < POS_END) ? r_acc_pos[IDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_acc_pos  <= n_acc_pos;
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1     <= i_load.data;
            r_s1_pos <= r_acc_pos;
        end
    end

    // change time table: write on a stamped action, registered read at accept
    always_ff @(posedge i_clk) begin
        if (w_stamp) begin
            r_ctime[n_best_idx] <= w_time;
        end
        if (w_acc) begin
            if (w_stamp && (n_best_idx == w_rd_addr)) begin
                r_rd <= w_time;
            end else begin
                r_rd <= r_ctime[w_rd_addr];
            end
        end
    end

    // compare the current record against the best kept so far
    always_comb begin
        w_first   = (r_s1_pos == '0);
        w_slot_ok = (r_s1_pos < POS_END);
        w_sidx    = w_slot_ok ? r_s1_pos[IDX_W-1:0] : '0;
        w_time    = w_first ? r_s1.time_now : r_time;
        w_head    = w_first ? r_s1.headroom : r_head;

        if (!w_first) begin
            w_mode = r_mode;
        end else if (r_s1.headroom < 0) begin
            w_mode = MODE_EMERGENCY;
        end else if (r_s1.soc_level < w_cfg.shed_th) begin
            w_mode = MODE_LOW;
        end else if (r_s1.soc_level > w_cfg.restore_th) begin
            w_mode = MODE_RECOVERY;
        end else begin
            w_mode = MODE_IDLE;
        end

        // wrapping time difference
        w_elapsed  = w_time - r_rd;
        w_dwell_ok = !r_seen[w_sidx] || (w_elapsed >= w_cfg.min_dwell);
        w_found    = w_first ? 1'b0 : r_best_found;

        case (w_mode)
            MODE_EMERGENCY, MODE_LOW: begin
                w_cand   = !r_s1.load_is_shed && (r_s1.load_priority != w_cfg.crit_prio)
                           && ((w_mode == MODE_EMERGENCY) || w_dwell_ok);
                w_better = !w_found || (r_s1.load_priority > r_best_prio);
            end
            MODE_RECOVERY: begin
                w_cand   = r_s1.load_is_shed && w_dwell_ok
                           && ($signed({1'b0, r_s1.load_demand}) <= w_head);
                w_better = !w_found || (r_s1.load_priority < r_best_prio);
            end
            default: begin
                w_cand   = 1'b0;
                w_better = 1'b0;
            end
        endcase

        w_take       = w_slot_ok && w_cand && w_better;
        n_best_found = w_found || w_take;
        n_best_idx   = w_take ? w_sidx : r_best_idx;
        n_best_prio  = w_take ? r_s1.load_priority : r_best_prio;
        w_stamp      = w_s1_fire && r_s1.last_load && n_best_found;

        w_idx_ext = {4'd0, n_best_idx};
        n_out.act_valid        = n_best_found;
        n_out.target_index     = n_best_found ? w_idx_ext[3:0] : 4'd0;
        n_out.shed_not_restore = n_best_found && (w_mode != MODE_RECOVERY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
            r_best_idx   <= '0;
            r_best_prio  <= '0;
            r_mode       <= MODE_IDLE;
            r_time       <= '0;
            r_head       <= '0;
            r_seen       <= '0;
        end else if (w_s1_fire) begin
            r_mode <= w_mode;
            r_time <= w_time;
            r_head <= w_head;
            if (r_s1.last_load) begin
                r_best_found <= 1'b0;
                r_best_idx   <= '0;
                r_best_prio  <= '0;
                if (n_best_found) begin
                    r_seen[n_best_idx] <= 1'b1;
                end
            end else begin
                r_best_found <= n_best_found;
                r_best_idx   <= n_best_idx;
                r_best_prio  <= n_best_prio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1.last_load) begin
            r_out_valid <= 1'b1;
        end else if (o_act.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1.last_load) begin
            r_out <= n_out;
        end
    end

    assign o_act.valid = r_out_valid;
    assign o_act.data  = r_out;

    `PLSS_ASSERT_NOW(a_pos_bound, 1'b1, r_acc_pos <= POS_END, "record position past table depth")
    `PLSS_ASSERT_NOW(a_idle_act_zero, o_act.valid && !o_act.data.act_valid,
        !o_act.data.shed_not_restore && (o_act.data.target_index == 4'd0),
        "no-action beat carries nonzero fields")
    `PLSS_ASSERT_NEXT(a_update_clears, w_s1_fire && r_s1.last_load,
        !r_best_found && o_act.valid, "update end did not clear best or raise action")
    `PLSS_ASSERT_NEXT(a_stamp_marks, w_stamp, r_seen[$past(n_best_idx)],
        "chosen load not marked as changed")
endmodule
